FILE: design/dsr_pkg.sv
// Shared types, codes and constants for the dual servo slew ramp.
package dsr_pkg;

   localparam logic [1:0] FUNC_TICK    = 2'd0;
   localparam logic [1:0] FUNC_MOVE    = 2'd1;
   localparam logic [1:0] FUNC_DISABLE = 2'd2;

   localparam logic [1:0] GS_DISABLED = 2'd0;
   localparam logic [1:0] GS_CLOSED   = 2'd1;
   localparam logic [1:0] GS_OPEN     = 2'd2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_GATE0_OPEN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE0_CLOSE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE1_OPEN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE1_CLOSE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_RATE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_RATE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TICKS   = 3'd6;

   localparam logic [16:0] FULL_Q16   = 17'd65536;
   localparam logic [16:0] NEAR_Q16   = 17'd6;
   localparam logic [16:0] CLOSED_Q16 = 17'd65530;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_MOVE,
      CMD_DISABLE,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [16:0]  target;
   } cmd_type;

   typedef struct packed {
      logic [15:0] gate0_open;
      logic [15:0] gate0_close;
      logic [15:0] gate1_open;
      logic [15:0] gate1_close;
      logic [31:0] open_rate;
      logic [31:0] close_rate;
      logic [47:0] open_span;
      logic [47:0] close_span;
   } cfg_type;

   typedef struct packed {
      logic        apply;
      logic [32:0] position;
      logic [1:0]  gate_status;
      logic        ramping;
      logic        move_done;
      logic [16:0] last_ratio;
   } result_type;

endpackage

FILE: design/dual_servo_slew_ramp.sv
// Top level of the dual servo gate slew-rate limiter.
//
//   channel   direction  handshake              payload
//   req_*     in         req_valid/req_ready    func, target_ratio
//   rsp_*     out        rsp_valid/rsp_ready    duty0, duty1, gate_status, ramping,
//                                               move_done, last_ratio
//   csr_*     in         csr_wr_en              csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp_ready stays high; a request passes
// through the 2-entry command queue, the executor (position add/compare) and its
// result register, then the level multipliers into the response register.
// Synchronous active-high reset clears all control state and the executor gate state.
// A stalled rsp_ready backs up through the executor into the queue; req_ready
// drops only when the queue is full.
module dual_servo_slew_ramp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_func,
   input  logic [16:0]                     req_target_ratio,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [15:0]                     rsp_duty0,
   output logic [15:0]                     rsp_duty1,
   output logic [1:0]                      rsp_gate_status,
   output logic                            rsp_ramping,
   output logic                            rsp_move_done,
   output logic [16:0]                     rsp_last_ratio,
   input  logic                            csr_wr_en,
   input  logic [dsr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dsr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dsr_pkg::*;

   cfg_type    cfg;
   logic       head_valid;
   cmd_type    head;
   logic       pop;
   logic       mid_valid;
   result_type mid;
   logic       mid_ready;

   dsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dsr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_target_ratio (req_target_ratio),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop)
   );

   dsr_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .mid_valid  (mid_valid),
      .mid        (mid),
      .mid_ready  (mid_ready)
   );

   dsr_levels u_levels (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .mid_valid       (mid_valid),
      .mid             (mid),
      .mid_ready       (mid_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_duty0       (rsp_duty0),
      .rsp_duty1       (rsp_duty1),
      .rsp_gate_status (rsp_gate_status),
      .rsp_ramping     (rsp_ramping),
      .rsp_move_done   (rsp_move_done),
      .rsp_last_ratio  (rsp_last_ratio)
   );

`ifndef NO_ASSERTIONS
   a_ramp_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_ramping && rsp_move_done))
      else $error("ramp reported active on a completing transaction");

   a_open_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_move_done && (rsp_gate_status != GS_DISABLED)
       && (rsp_last_ratio <= NEAR_Q16)) |-> (rsp_gate_status == GS_OPEN))
      else $error("move to open finished without open state");

   a_closed_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_move_done && (rsp_gate_status != GS_DISABLED)
       && (rsp_last_ratio >= CLOSED_Q16)) |-> (rsp_gate_status == GS_CLOSED))
      else $error("move to closed finished without closed state");
`endif

endmodule

FILE: design/dsr_csr.sv
// Configuration registers and precomputed minimum ramp spans.
module dsr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [dsr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dsr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output dsr_pkg::cfg_type                cfg
);
   import dsr_pkg::*;

   logic [15:0] g0_open_ff, g0_close_ff, g1_open_ff, g1_close_ff;
   logic [31:0] open_rate_ff, close_rate_ff;
   logic [15:0] min_ticks_ff;
   logic [31:0] open_eff, close_eff;
   logic [47:0] open_span_in, close_span_in;
   logic [47:0] open_span_ff, close_span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g0_open_ff    <= 16'd3277;
         g0_close_ff   <= 16'd5898;
         g1_open_ff    <= 16'd5898;
         g1_close_ff   <= 16'd3277;
         open_rate_ff  <= 32'd21475;
         close_rate_ff <= 32'd12885;
         min_ticks_ff  <= 16'd1000;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GATE0_OPEN:  g0_open_ff    <= csr_wdata[15:0];
            CSR_GATE0_CLOSE: g0_close_ff   <= csr_wdata[15:0];
            CSR_GATE1_OPEN:  g1_open_ff    <= csr_wdata[15:0];
            CSR_GATE1_CLOSE: g1_close_ff   <= csr_wdata[15:0];
            CSR_OPEN_RATE:   open_rate_ff  <= csr_wdata[31:0];
            CSR_CLOSE_RATE:  close_rate_ff <= csr_wdata[31:0];
            CSR_MIN_TICKS:   min_ticks_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // zero rate behaves as one
   assign open_eff  = (open_rate_ff == 32'd0) ? 32'd1 : open_rate_ff;
   assign close_eff = (close_rate_ff == 32'd0) ? 32'd1 : close_rate_ff;

   // floor(dist / rate) < min  <=>  dist < min * rate
   assign open_span_in  = 48'(open_eff) * 48'(min_ticks_ff);
   assign close_span_in = 48'(close_eff) * 48'(min_ticks_ff);

   always_ff @(posedge clock) begin
      open_span_ff  <= open_span_in;
      close_span_ff <= close_span_in;
   end

   assign cfg.gate0_open  = g0_open_ff;
   assign cfg.gate0_close = g0_close_ff;
   assign cfg.gate1_open  = g1_open_ff;
   assign cfg.gate1_close = g1_close_ff;
   assign cfg.open_rate   = open_eff;
   assign cfg.close_rate  = close_eff;
   assign cfg.open_span   = open_span_ff;
   assign cfg.close_span  = close_span_ff;

endmodule

FILE: design/dsr_front.sv
// Front end: decodes request transactions and queues them for the executor.
module dsr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  logic [16:0]       req_target_ratio,
   output logic              head_valid,
   output dsr_pkg::cmd_type  head,
   input  logic              pop
);
   import dsr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   cmd_type             decoded;
   logic                push;
   logic                take;

   always_comb begin
      unique case (req_func)
         FUNC_TICK:    decoded.kind = CMD_TICK;
         FUNC_MOVE:    decoded.kind = CMD_MOVE;
         FUNC_DISABLE: decoded.kind = CMD_DISABLE;
         default:      decoded.kind = CMD_NOP;
      endcase
      decoded.target = (req_target_ratio > FULL_Q16) ? FULL_Q16 : req_target_ratio;
   end

   assign req_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign take       = pop && head_valid;
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

FILE: design/dsr_exec.sv
// Executor: gate position, ramp and pending-command state, one command per cycle while mid_ready is high.
module dsr_exec (
   input  logic                clock,
   input  logic                reset,
   input  dsr_pkg::cfg_type    cfg,
   input  logic                head_valid,
   input  dsr_pkg::cmd_type    head,
   output logic                pop,
   output logic                mid_valid,
   output dsr_pkg::result_type mid,
   input  logic                mid_ready
);
   import dsr_pkg::*;

   logic [32:0] pos_ff, pos_in;
   logic [16:0] tgt_ff, tgt_in;
   logic        known_ff, known_in;
   logic        ramp_ff, ramp_in;
   logic        toopen_ff, toopen_in;
   logic        pend_v_ff, pend_v_in;
   logic        pend_dis_ff, pend_dis_in;
   logic [16:0] pend_tgt_ff, pend_tgt_in;
   logic [1:0]  gstate_ff, gstate_in;
   logic [16:0] last_ff, last_in;
   logic        mid_valid_ff, mid_valid_in;
   result_type  mid_ff, mid_in;

   logic        fire;
   logic        use_pending;
   logic [16:0] exec_t;
   logic        exec_dis;
   logic        to_open;
   logic [16:0] dist16;
   logic [47:0] span;
   logic        short_move;
   logic [31:0] rate;
   logic [32:0] goal;
   logic [32:0] exec_pos;
   logic        reached;
   logic [32:0] step_pos;
   logic        apply;
   logic        done;
   logic        do_exec;
   logic        finish;
   logic [16:0] finish_t;

   assign fire = head_valid && mid_ready;
   assign pop  = fire;

   assign use_pending = (head.kind == CMD_TICK);
   assign exec_t      = use_pending ? pend_tgt_ff : head.target;
   assign exec_dis    = use_pending ? pend_dis_ff : (head.kind == CMD_DISABLE);
   assign exec_pos    = {exec_t, 16'd0};

   assign to_open    = (exec_t < tgt_ff);
   assign dist16     = to_open ? (tgt_ff - exec_t) : (exec_t - tgt_ff);
   assign span       = to_open ? cfg.open_span : cfg.close_span;
   assign short_move = (48'({dist16, 16'd0}) < span);

   assign rate = toopen_ff ? cfg.open_rate : cfg.close_rate;
   assign goal = {tgt_ff, 16'd0};

   always_comb begin
      if (toopen_ff) begin
         reached  = (pos_ff <= goal) || ((pos_ff - goal) <= {1'b0, rate});
         step_pos = pos_ff - {1'b0, rate};
      end else begin
         reached  = (pos_ff >= goal) || ((goal - pos_ff) <= {1'b0, rate});
         step_pos = pos_ff + {1'b0, rate};
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      tgt_in      = tgt_ff;
      known_in    = known_ff;
      ramp_in     = ramp_ff;
      toopen_in   = toopen_ff;
      pend_v_in   = pend_v_ff;
      pend_dis_in = pend_dis_ff;
      pend_tgt_in = pend_tgt_ff;
      gstate_in   = gstate_ff;
      last_in     = last_ff;
      apply       = 1'b0;
      done        = 1'b0;
      do_exec     = 1'b0;
      finish      = 1'b0;
      finish_t    = exec_t;

      if (fire) begin
         unique case (head.kind)
            CMD_TICK: begin
               if (ramp_ff) begin
                  apply = 1'b1;
                  if (reached) begin
                     pos_in   = goal;
                     ramp_in  = 1'b0;
                     finish   = 1'b1;
                     finish_t = tgt_ff;
                  end else begin
                     pos_in = step_pos;
                  end
               end else if (pend_v_ff) begin
                  pend_v_in = 1'b0;
                  do_exec   = 1'b1;
               end
            end
            CMD_MOVE, CMD_DISABLE: begin
               if (ramp_ff || pend_v_ff) begin
                  pend_v_in   = 1'b1;
                  pend_dis_in = (head.kind == CMD_DISABLE);
                  pend_tgt_in = head.target;
               end else begin
                  do_exec = 1'b1;
               end
            end
            CMD_NOP: ;
         endcase
      end

      if (do_exec) begin
         if (exec_dis) begin
            gstate_in = GS_DISABLED;
            done      = 1'b1;
         end else if (!known_ff) begin
            known_in = 1'b1;
            pos_in   = exec_pos;
            apply    = 1'b1;
            finish   = 1'b1;
         end else if (dist16 <= NEAR_Q16) begin
            pos_in = exec_pos;
            finish = 1'b1;
         end else if (short_move) begin
            pos_in = exec_pos;
            apply  = 1'b1;
            finish = 1'b1;
         end else begin
            ramp_in   = 1'b1;
            toopen_in = to_open;
            tgt_in    = exec_t;
         end
      end

      if (finish) begin
         tgt_in  = finish_t;
         last_in = finish_t;
         done    = 1'b1;
         if (finish_t <= NEAR_Q16) begin
            gstate_in = GS_OPEN;
         end else if (finish_t >= CLOSED_Q16) begin
            gstate_in = GS_CLOSED;
         end
      end

      mid_in.apply       = apply;
      mid_in.position    = pos_in;
      mid_in.gate_status = gstate_in;
      mid_in.ramping     = ramp_in;
      mid_in.move_done   = done;
      mid_in.last_ratio  = last_in;

      mid_valid_in = mid_ready ? head_valid : mid_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         tgt_ff       <= '0;
         known_ff     <= 1'b0;
         ramp_ff      <= 1'b0;
         toopen_ff    <= 1'b0;
         pend_v_ff    <= 1'b0;
         pend_dis_ff  <= 1'b0;
         pend_tgt_ff  <= '0;
         gstate_ff    <= GS_DISABLED;
         last_ff      <= '0;
         mid_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         tgt_ff       <= tgt_in;
         known_ff     <= known_in;
         ramp_ff      <= ramp_in;
         toopen_ff    <= toopen_in;
         pend_v_ff    <= pend_v_in;
         pend_dis_ff  <= pend_dis_in;
         pend_tgt_ff  <= pend_tgt_in;
         gstate_ff    <= gstate_in;
         last_ff      <= last_in;
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid       = mid_ff;

endmodule

FILE: design/dsr_levels.sv
// Back stage: servo level interpolation and the response register.
module dsr_levels (
   input  logic                clock,
   input  logic                reset,
   input  dsr_pkg::cfg_type    cfg,
   input  logic                mid_valid,
   input  dsr_pkg::result_type mid,
   output logic                mid_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_duty0,
   output logic [15:0]         rsp_duty1,
   output logic [1:0]          rsp_gate_status,
   output logic                rsp_ramping,
   output logic                rsp_move_done,
   output logic [16:0]         rsp_last_ratio
);
   import dsr_pkg::*;

   function automatic logic [15:0] interp(input logic [15:0] open_lvl,
                                          input logic [15:0] close_lvl,
                                          input logic [32:0] pos);
      logic [15:0] span;
      logic [49:0] prod;
      logic [15:0] res;
      if (close_lvl >= open_lvl) begin
         span = close_lvl - open_lvl;
         prod = 50'(span) * 50'(pos);
         res  = open_lvl + prod[47:32];
      end else begin
         span = open_lvl - close_lvl;
         prod = 50'(span) * 50'(pos) + 50'h0_FFFF_FFFF;
         res  = open_lvl - prod[47:32];
      end
      return res;
   endfunction

   logic        valid_ff;
   logic [15:0] duty0_ff, duty1_ff;
   logic [1:0]  gstate_ff;
   logic        ramping_ff;
   logic        done_ff;
   logic [16:0] last_ff;
   logic [15:0] lvl0, lvl1;
   logic        load;

   assign mid_ready = !valid_ff || rsp_ready;
   assign load      = mid_valid && mid_ready;
   assign lvl0      = interp(cfg.gate0_open, cfg.gate0_close, mid.position);
   assign lvl1      = interp(cfg.gate1_open, cfg.gate1_close, mid.position);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         duty0_ff <= '0;
         duty1_ff <= '0;
      end else begin
         if (mid_ready) begin
            valid_ff <= mid_valid;
         end
         if (load && mid.apply) begin
            duty0_ff <= lvl0;
            duty1_ff <= lvl1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         gstate_ff  <= mid.gate_status;
         ramping_ff <= mid.ramping;
         done_ff    <= mid.move_done;
         last_ff    <= mid.last_ratio;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_duty0       = duty0_ff;
   assign rsp_duty1       = duty1_ff;
   assign rsp_gate_status = gstate_ff;
   assign rsp_ramping     = ramping_ff;
   assign rsp_move_done   = done_ff;
   assign rsp_last_ratio  = last_ff;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the dual servo slew ramp: directed and random gate traffic.
`timescale 1ns / 1ps

module testbench;
   import dsr_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [15:0] duty0;
      logic [15:0] duty1;
      logic [1:0]  gate_status;
      logic        ramping;
      logic        move_done;
      logic [16:0] last_ratio;
   } gate_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_func = FUNC_TICK;
   logic [16:0]           req_target_ratio = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [15:0]           rsp_duty0;
   logic [15:0]           rsp_duty1;
   logic [1:0]            rsp_gate_status;
   logic                  rsp_ramping;
   logic                  rsp_move_done;
   logic [16:0]           rsp_last_ratio;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_GATE0_OPEN;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   dual_servo_slew_ramp dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_target_ratio (req_target_ratio),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_duty0        (rsp_duty0),
      .rsp_duty1        (rsp_duty1),
      .rsp_gate_status  (rsp_gate_status),
      .rsp_ramping      (rsp_ramping),
      .rsp_move_done    (rsp_move_done),
      .rsp_last_ratio   (rsp_last_ratio),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // gate model: configuration
   logic [15:0] g0_open = 16'd3277;
   logic [15:0] g0_close = 16'd5898;
   logic [15:0] g1_open = 16'd5898;
   logic [15:0] g1_close = 16'd3277;
   logic [15:0] min_ticks = 16'd1000;
   logic [31:0] rate_open = 32'd21475;
   logic [31:0] rate_close = 32'd12885;

   // gate model: state
   logic [63:0] pos_q32 = '0;
   logic [16:0] dest_q16 = '0;
   logic [16:0] parked_target = '0;
   logic [16:0] done_ratio = '0;
   logic [1:0]  gate_rep = GS_DISABLED;
   logic [15:0] lvl0 = '0;
   logic [15:0] lvl1 = '0;
   bit          pos_known = 0;
   bit          ramp_on = 0;
   bit          ramp_open_dir = 0;
   bit          cmd_parked = 0;
   bit          parked_disable = 0;
   bit          move_fin = 0;

   gate_report_type gate_reports[$];
   gate_report_type want;

   int src_idle_pct = 13;
   int sink_stall_pct = 79;
   int mismatches = 0;
   int n_items = 0;
   int n_done = 0;
   int n_writes = 0;
   int ramp_steps = 0;
   int quiet_cycles = 0;

   function automatic logic [15:0] servo_level(input logic [15:0] lo, input logic [15:0] hi,
                                               input logic [63:0] pos);
      logic [63:0] span;
      if (hi >= lo) begin
         span = 64'(hi) - 64'(lo);
         return 16'(64'(lo) + ((span * pos) >> 32));
      end
      span = 64'(lo) - 64'(hi);
      return 16'(64'(lo) - ((span * pos + 64'hFFFF_FFFF) >> 32));
   endfunction

   function automatic void set_servos();
      lvl0 = servo_level(g0_open, g0_close, pos_q32);
      lvl1 = servo_level(g1_open, g1_close, pos_q32);
   endfunction

   function automatic void complete_move(input logic [16:0] t);
      dest_q16 = t;
      if (t <= NEAR_Q16) gate_rep = GS_OPEN;
      else if (t >= CLOSED_Q16) gate_rep = GS_CLOSED;
      done_ratio = t;
      move_fin = 1;
   endfunction

   function automatic void run_command(input bit is_disable, input logic [16:0] tgt);
      logic [16:0] t;
      logic [16:0] gap;
      logic [63:0] rate;
      bit          to_open;
      if (is_disable) begin
         gate_rep = GS_DISABLED;
         move_fin = 1;
         return;
      end
      t = (tgt > FULL_Q16) ? FULL_Q16 : tgt;
      if (!pos_known) begin
         pos_known = 1;
         pos_q32 = 64'(t) << 16;
         set_servos();
         complete_move(t);
         return;
      end
      to_open = t < dest_q16;
      gap = to_open ? dest_q16 - t : t - dest_q16;
      rate = 64'(to_open ? rate_open : rate_close);
      if (rate == 64'd0) rate = 64'd1;
      if (gap <= NEAR_Q16) begin
         pos_q32 = 64'(t) << 16;
         complete_move(t);
      end else if ((64'(gap) << 16) / rate < 64'(min_ticks)) begin
         pos_q32 = 64'(t) << 16;
         set_servos();
         complete_move(t);
      end else begin
         ramp_on = 1;
         ramp_open_dir = to_open;
         dest_q16 = t;
      end
   endfunction

   function automatic gate_report_type predict_report(input logic [1:0] f,
                                                      input logic [16:0] tgt);
      gate_report_type r;
      logic [63:0]  goal;
      logic [63:0]  rate;
      bit           reached;
      move_fin = 0;
      case (f)
         FUNC_TICK: begin
            if (ramp_on) begin
               goal = 64'(dest_q16) << 16;
               rate = 64'(ramp_open_dir ? rate_open : rate_close);
               if (rate == 64'd0) rate = 64'd1;
               if (ramp_open_dir) begin
                  reached = (pos_q32 <= goal) || (pos_q32 - goal <= rate);
                  if (!reached) pos_q32 = pos_q32 - rate;
               end else begin
                  reached = (pos_q32 >= goal) || (goal - pos_q32 <= rate);
                  if (!reached) pos_q32 = pos_q32 + rate;
               end
               if (reached) begin
                  pos_q32 = goal;
                  ramp_on = 0;
                  set_servos();
                  complete_move(dest_q16);
               end else begin
                  set_servos();
               end
               ramp_steps++;
            end else if (cmd_parked) begin
               cmd_parked = 0;
               run_command(parked_disable, parked_target);
            end
         end
         FUNC_MOVE, FUNC_DISABLE: begin
            if (ramp_on || cmd_parked) begin
               cmd_parked = 1;
               parked_disable = (f == FUNC_DISABLE);
               parked_target = tgt;
            end else begin
               run_command(f == FUNC_DISABLE, tgt);
            end
         end
         default: begin
         end
      endcase
      r.duty0 = lvl0;
      r.duty1 = lvl1;
      r.gate_status = gate_rep;
      r.ramping = ramp_on;
      r.move_done = move_fin;
      r.last_ratio = done_ratio;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] got_v);
      if (exp_v !== got_v) begin
         if (mismatches < 40)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            gate_reports.push_back(predict_report(req_func, req_target_ratio));
            n_items++;
         end
         if (rsp_valid && rsp_ready) begin
            if (gate_reports.size() == 0) begin
               $display("%0t: unexpected transaction on rsp: expected none, got duty0 %0d",
                        $time, rsp_duty0);
               mismatches++;
            end else begin
               want = gate_reports.pop_front();
               check_field("duty0", 32'(want.duty0), 32'(rsp_duty0));
               check_field("duty1", 32'(want.duty1), 32'(rsp_duty1));
               check_field("gate_status", 32'(want.gate_status), 32'(rsp_gate_status));
               check_field("ramping", 32'(want.ramping), 32'(rsp_ramping));
               check_field("move_done", 32'(want.move_done), 32'(rsp_move_done));
               check_field("last_ratio", 32'(want.last_ratio), 32'(rsp_last_ratio));
               n_done += int'(rsp_move_done);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d transactions still outstanding", $time,
                     gate_reports.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [1:0] f, input logic [16:0] t);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_target_ratio <= t;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_item(FUNC_TICK, 17'($urandom_range(131071)));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (gate_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_GATE0_OPEN:  g0_open = val[15:0];
         CSR_GATE0_CLOSE: g0_close = val[15:0];
         CSR_GATE1_OPEN:  g1_open = val[15:0];
         CSR_GATE1_CLOSE: g1_close = val[15:0];
         CSR_OPEN_RATE:   rate_open = val;
         CSR_CLOSE_RATE:  rate_close = val;
         CSR_MIN_TICKS:   min_ticks = val[15:0];
         default: begin
         end
      endcase
      n_writes++;
      @(posedge clock);
   endtask

   task automatic load_gate_config(input logic [15:0] o0, input logic [15:0] c0,
                                   input logic [15:0] o1, input logic [15:0] c1,
                                   input logic [31:0] ro, input logic [31:0] rc,
                                   input logic [15:0] mt);
      write_reg(CSR_GATE0_OPEN, 32'(o0));
      write_reg(CSR_GATE0_CLOSE, 32'(c0));
      write_reg(CSR_GATE1_OPEN, 32'(o1));
      write_reg(CSR_GATE1_CLOSE, 32'(c1));
      write_reg(CSR_OPEN_RATE, ro);
      write_reg(CSR_CLOSE_RATE, rc);
      write_reg(CSR_MIN_TICKS, 32'(mt));
   endtask

   function automatic logic [16:0] pick_target();
      int v;
      case ($urandom_range(7))
         0: return '0;
         1: return FULL_Q16;
         2: return 17'($urandom_range(131071, 65537));
         3: begin
            v = int'(dest_q16) + int'($urandom_range(12)) - 6;
            return (v < 0) ? 17'd0 : 17'(v);
         end
         4: return 17'($urandom_range(32'(NEAR_Q16)));
         5: return 17'($urandom_range(65536, 65530));
         6: return $urandom_range(1) ? 17'd7 : 17'd65529;
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   // runs on reset register values: first move, saturation, tiny change, short jump
   task automatic test_reset_values();
      send_item(FUNC_TICK, '0);
      send_item(FUNC_UNUSED, 17'h1FFFF);
      send_item(FUNC_DISABLE, '0);
      send_item(FUNC_MOVE, 17'h1FFFF);
      send_item(FUNC_MOVE, 17'd65533);
      send_item(FUNC_MOVE, 17'd65236);
      send_item(FUNC_MOVE, 17'd65240);
      settle();
   endtask

   task automatic test_ramp_and_pending();
      load_gate_config(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 32'h4000_0000, 32'h6000_0000, 16'd2);
      send_item(FUNC_MOVE, '0);
      send_item(FUNC_MOVE, 17'd40000);
      send_item(FUNC_DISABLE, 17'd1234);
      send_ticks(5);
      send_item(FUNC_MOVE, FULL_Q16);
      send_ticks(3);
      send_item(FUNC_MOVE, 17'd65531);
      settle();
   endtask

   // zero rate counts as one step, then the widest rate finishes in a single tick
   task automatic test_rate_extremes();
      load_gate_config(16'hFFFF, 16'd0, 16'd1234, 16'd1234, 32'd0, 32'd0, 16'd0);
      send_item(FUNC_MOVE, 17'd30000);
      send_ticks(3);
      settle();
      write_reg(CSR_OPEN_RATE, 32'hFFFF_FFFF);
      write_reg(CSR_CLOSE_RATE, 32'hFFFF_FFFF);
      send_ticks(2);
      send_item(FUNC_MOVE, FULL_Q16);
      send_ticks(1);
      settle();
      write_reg(CSR_MIN_TICKS, 32'h0000_FFFF);
      send_item(FUNC_MOVE, '0);
      settle();
   endtask

   task automatic run_burst(input int n_target);
      int sent;
      int roll;
      int k;
      sent = 0;
      while (sent < n_target) begin
         roll = $urandom_range(99);
         if (roll < 65) begin
            send_item(FUNC_MOVE, pick_target());
            k = $urandom_range(40);
            send_ticks(k);
            sent += k + 1;
         end else if (roll < 75) begin
            send_item(FUNC_DISABLE, 17'($urandom_range(131071)));
            send_ticks(2);
            sent += 3;
         end else if (roll < 85) begin
            send_item(FUNC_MOVE, pick_target());
            send_item($urandom_range(1) ? FUNC_MOVE : FUNC_DISABLE, pick_target());
            sent += 2;
         end else if (roll < 92) begin
            send_item(FUNC_UNUSED, 17'($urandom_range(131071)));
            sent++;
         end else begin
            send_item(2'($urandom_range(3)), 17'($urandom_range(131071)));
            sent++;
         end
      end
      settle();
   endtask

   task automatic test_random_traffic();
      for (int mode = 0; mode < 3; mode++) begin
         src_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 79 : 0;
         sink_stall_pct = (mode == 0) ? 79 : (mode == 1) ? 13 : 0;
         for (int k = 0; k < 3; k++) begin
            load_gate_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                             16'($urandom_range(65535)), 16'($urandom_range(65535)),
                             32'($urandom_range(32'hFFFF_FFFF, 32'h0400_0000)),
                             32'($urandom_range(32'hFFFF_FFFF, 32'h0400_0000)),
                             (k == 2) ? 16'($urandom_range(65535)) : 16'($urandom_range(12)));
            run_burst(150);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_ramp_and_pending();
      test_rate_extremes();
      test_random_traffic();
      settle();
      repeat (8) @(posedge clock);
      $display("Covered %0d transactions: %0d ramp steps, %0d completed moves or disables,",
               n_items, ramp_steps, n_done);
      $display("%0d register writes across three backpressure patterns, %0d mismatches.",
               n_writes, mismatches);
      if (mismatches == 0 && gate_reports.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/dsr_pkg.sv
design/dsr_csr.sv
design/dsr_front.sv
design/dsr_exec.sv
design/dsr_levels.sv
design/dual_servo_slew_ramp.sv
dv/testbench.sv
